/* rtl/tcw_pkg.sv */
// Shared types and constants for the text console character writer.
`default_nettype none

package tcw_pkg;

  // Operation codes carried in the opcode field of a command item.
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_SET   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_BLANK,
    ST_DONE
  } state_t;

  // Field widths of the command, response and configuration channels.
  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int COORD_W  = 8;
  localparam int OCOL_W   = 7;
  localparam int OROW_W   = 5;
  localparam int OLIN_W   = 11;
  localparam int CELL_W   = 16;
  localparam int COLOR_W  = 8;

  // Control characters and blank cell contents.
  localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0]  CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0]  CH_SPACE     = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

endpackage

`default_nettype wire

/* rtl/tcw_if.sv */
// Channel interfaces for the command, response and configuration ports.
`default_nettype none

interface tcw_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [tcw_pkg::OP_W-1:0]       opcode;
  logic [tcw_pkg::CHAR_W-1:0]     char_code;
  logic [tcw_pkg::COORD_W-1:0]    col;
  logic [tcw_pkg::COORD_W-1:0]    row;

  modport source (output valid, opcode, char_code, col, row, input ready);
  modport sink   (input valid, opcode, char_code, col, row, output ready);
endinterface

interface tcw_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [tcw_pkg::OCOL_W-1:0]     cursor_col;
  logic [tcw_pkg::OROW_W-1:0]     cursor_row;
  logic [tcw_pkg::OLIN_W-1:0]     cursor_linear;
  logic [tcw_pkg::CELL_W-1:0]     cell_value;
  logic                           did_scroll;

  modport source (output valid, cursor_col, cursor_row, cursor_linear, cell_value,
                  did_scroll, input ready);
  modport sink   (input valid, cursor_col, cursor_row, cursor_linear, cell_value,
                  did_scroll, output ready);
endinterface

interface tcw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tcw_pkg::COLOR_W-1:0]    data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/text_console_char_writer.sv */
// Top level of the text console character writer: screen memory, cursor and controller.
//
//   channel | direction | payload                                          | accepted when
//   --------+-----------+--------------------------------------------------+--------------
//   cmd     | in        | opcode, char_code, col, row                      | valid & ready
//   rsp     | out       | cursor_col, cursor_row, cursor_linear,           | valid & ready
//           |           | cell_value, did_scroll                           |
//   cfg     | in        | data (text_color)                                | valid & ready
//
// For a put, set-cursor or read-cell item the accept cycle does any screen memory
// access (a put of a printable character writes one cell, a read-cell reads one),
// then the done state loads the response register once it is free.
// A clear and a scrolling put take longer, as the one-write, one-read port of the
// screen memory walks every cell. After reset the block blanks the screen memory and
// takes no command item until it is done; configuration writes are taken at any time.
// A result waiting in the response register does not stop the next item from being
// accepted; only the completion of that next item waits for the register to drain.
`default_nettype none

module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst,
  tcw_cfg_if.sink    cfg,
  tcw_cmd_if.sink    cmd,
  tcw_rsp_if.source  rsp
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  // Widths wide enough for both the internal value and the masked output field.
  localparam int CX    = (CW > tcw_pkg::OCOL_W) ? CW : tcw_pkg::OCOL_W;
  localparam int RX    = (RW > tcw_pkg::OROW_W) ? RW : tcw_pkg::OROW_W;
  localparam int LX    = (AW > tcw_pkg::OLIN_W) ? AW : tcw_pkg::OLIN_W;

  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_COPY = AW'(CELLS - COLUMNS);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [tcw_pkg::COORD_W:0] COLS_LIM = (tcw_pkg::COORD_W + 1)'(COLUMNS);
  localparam logic [tcw_pkg::COORD_W:0] ROWS_LIM = (tcw_pkg::COORD_W + 1)'(ROWS);

  // Row-major cell index of a cursor position.
  function automatic logic [AW-1:0] lin_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(AW'(r) * COLS_A) + AW'(c);
  endfunction

  // ---------------------------------------------------------------------------
  // Screen memory: one write port and one registered read port.
  // ---------------------------------------------------------------------------
  logic [tcw_pkg::CELL_W-1:0] screen_cells [CELLS];
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_cells[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= screen_cells[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration register. The port never stalls.
  // ---------------------------------------------------------------------------
  logic [tcw_pkg::COLOR_W-1:0] text_color;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tcw_pkg::RESET_COLOR;
    end else if (cfg.valid) begin
      text_color <= cfg.data;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller state.
  // ---------------------------------------------------------------------------
  tcw_pkg::state_t state, state_next;
  logic [CW-1:0]   cur_col, cur_col_next;
  logic [RW-1:0]   cur_row, cur_row_next;
  logic [AW-1:0]   cnt, cnt_next;
  logic            pend_scroll, pend_scroll_next;
  logic            pend_read, pend_read_next;
  logic            load_out;

  // Response register.
  logic                        out_valid;
  logic [tcw_pkg::OCOL_W-1:0]  out_col;
  logic [tcw_pkg::OROW_W-1:0]  out_row;
  logic [tcw_pkg::OLIN_W-1:0]  out_lin;
  logic [tcw_pkg::CELL_W-1:0]  out_cell;
  logic                        out_scroll;

  logic cmd_fire;
  assign cmd.ready = (state == tcw_pkg::ST_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;

  // Clamped coordinates for set-cursor and read-cell.
  logic [CW-1:0] clamp_col;
  logic [RW-1:0] clamp_row;
  assign clamp_col = ({1'b0, cmd.col} >= COLS_LIM) ? LAST_COL : cmd.col[CW-1:0];
  assign clamp_row = ({1'b0, cmd.row} >= ROWS_LIM) ? LAST_ROW : cmd.row[RW-1:0];

  // Cursor forms for the response, widened before masking to the field widths.
  logic [CX-1:0] col_x;
  logic [RX-1:0] row_x;
  logic [LX-1:0] lin_x;
  assign col_x = CX'(cur_col);
  assign row_x = RX'(cur_row);
  assign lin_x = LX'(lin_of(cur_row, cur_col));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tcw_pkg::ST_INIT;
      cur_col     <= '0;
      cur_row     <= '0;
      cnt         <= '0;
      pend_scroll <= 1'b0;
      pend_read   <= 1'b0;
    end else begin
      state       <= state_next;
      cur_col     <= cur_col_next;
      cur_row     <= cur_row_next;
      cnt         <= cnt_next;
      pend_scroll <= pend_scroll_next;
      pend_read   <= pend_read_next;
    end
  end

  always_comb begin
    state_next       = state;
    cur_col_next     = cur_col;
    cur_row_next     = cur_row;
    cnt_next         = cnt;
    pend_scroll_next = pend_scroll;
    pend_read_next   = pend_read;
    load_out         = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = cnt;
    mem_wdata        = {text_color, tcw_pkg::CH_SPACE};
    mem_re           = 1'b0;
    mem_raddr        = cnt;

    unique case (state)
      tcw_pkg::ST_INIT: begin
        // The power-up screen is blank in the reset color, whatever is configured.
        mem_we    = 1'b1;
        mem_wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::CH_SPACE};
        if (cnt == LAST_CELL) begin
          cnt_next   = '0;
          state_next = tcw_pkg::ST_IDLE;
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end

      tcw_pkg::ST_IDLE: begin
        if (cmd_fire) begin
          pend_scroll_next = 1'b0;
          pend_read_next   = 1'b0;
          state_next       = tcw_pkg::ST_DONE;
          unique case (tcw_pkg::op_t'(cmd.opcode))
            tcw_pkg::OP_PUT: begin
              case (cmd.char_code)
                tcw_pkg::CH_NEWLINE: begin
                  cur_col_next = '0;
                  if (cur_row == LAST_ROW) begin
                    pend_scroll_next = 1'b1;
                    cnt_next         = '0;
                    state_next       = tcw_pkg::ST_SCROLL;
                  end else begin
                    cur_row_next = cur_row + RW'(1);
                  end
                end
                tcw_pkg::CH_RETURN: begin
                  cur_col_next = '0;
                end
                tcw_pkg::CH_BACKSPACE: begin
                  if (cur_col != '0) begin
                    cur_col_next = cur_col - CW'(1);
                  end else if (cur_row != '0) begin
                    cur_row_next = cur_row - RW'(1);
                    cur_col_next = LAST_COL;
                  end
                end
                default: begin
                  mem_we    = 1'b1;
                  mem_waddr = lin_of(cur_row, cur_col);
                  mem_wdata = {text_color, cmd.char_code};
                  if (cur_col == LAST_COL) begin
                    cur_col_next = '0;
                    if (cur_row == LAST_ROW) begin
                      pend_scroll_next = 1'b1;
                      cnt_next         = '0;
                      state_next       = tcw_pkg::ST_SCROLL;
                    end else begin
                      cur_row_next = cur_row + RW'(1);
                    end
                  end else begin
                    cur_col_next = cur_col + CW'(1);
                  end
                end
              endcase
            end
            tcw_pkg::OP_CLEAR: begin
              cur_col_next = '0;
              cur_row_next = '0;
              cnt_next     = '0;
              state_next   = tcw_pkg::ST_BLANK;
            end
            tcw_pkg::OP_SET: begin
              cur_col_next = clamp_col;
              cur_row_next = clamp_row;
            end
            tcw_pkg::OP_READ: begin
              mem_re         = 1'b1;
              mem_raddr      = lin_of(clamp_row, clamp_col);
              pend_read_next = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      tcw_pkg::ST_SCROLL: begin
        // Read one row ahead and write the cell read in the previous cycle.
        if (cnt != LAST_COPY) begin
          mem_re    = 1'b1;
          mem_raddr = cnt + COLS_A;
        end
        if (cnt != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt - AW'(1);
          mem_wdata = rd_data;
        end
        if (cnt == LAST_COPY) begin
          state_next = tcw_pkg::ST_BLANK;
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end

      tcw_pkg::ST_BLANK: begin
        mem_we = 1'b1;
        if (cnt == LAST_CELL) begin
          cnt_next   = '0;
          state_next = tcw_pkg::ST_DONE;
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end

      tcw_pkg::ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = tcw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Response register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_col    <= col_x[tcw_pkg::OCOL_W-1:0];
      out_row    <= row_x[tcw_pkg::OROW_W-1:0];
      out_lin    <= lin_x[tcw_pkg::OLIN_W-1:0];
      out_cell   <= pend_read ? rd_data : '0;
      out_scroll <= pend_scroll;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.cursor_col    = out_col;
  assign rsp.cursor_row    = out_row;
  assign rsp.cursor_linear = out_lin;
  assign rsp.cell_value    = out_cell;
  assign rsp.did_scroll    = out_scroll;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // The cursor never leaves the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_col) < COLUMNS) && (32'(cur_row) < ROWS))
    else $error("cursor outside the screen");

  // During a scroll the write never lands on the cell being read.
  a_copy_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("screen memory read and write collide");

  // A scrolled result always reports the cursor on the bottom row.
  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    load_out && pend_scroll |=> (row_x[tcw_pkg::OROW_W-1:0] == rsp.cursor_row) &&
                                (cur_row == LAST_ROW))
    else $error("scroll reported off the bottom row");

  // Only a read-cell item returns a cell value.
  a_cell_only_read: assert property (@(posedge clk) disable iff (rst)
    load_out && !pend_read |=> (rsp.cell_value == '0))
    else $error("cell value on a non-read item");

endmodule

`default_nettype wire
